/* rtl/core/rbds_pkg.sv */
// ----------------------------------------------------------------------------
// rbds_pkg
// Shared widths, codes, reset values and types of the ring buffer DMA
// segmenter.
// ----------------------------------------------------------------------------
`default_nettype none

package rbds_pkg;

    localparam int HOST_W = 32;
    localparam int AUX_W  = 24;
    localparam int CNT_W  = 24;
    localparam int END_W  = 25;
    localparam int PTR_W  = END_W;
    localparam int ALU_W  = 33;
    localparam int IDX_W  = 4;

    localparam logic [AUX_W-1:0] RING_START_RST = 24'h00_0020;
    localparam logic [END_W-1:0] RING_END_RST   = 25'h000_4000;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [IDX_W-1:0] {
        REG_RING_START = 4'd0,
        REG_RING_END   = 4'd1
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CAP,
        ST_AVAIL,
        ST_CHECK,
        ST_FIRST,
        ST_MIN,
        ST_REST,
        ST_ADV,
        ST_WRAP,
        ST_ADV2,
        ST_WRAP2,
        ST_FILL,
        ST_FREE,
        ST_EMIT1,
        ST_EMIT2
    } state_t;

    // Ring window as seen by the sequencer, plus the empty-ring request
    // raised by a register write.
    typedef struct packed {
        logic [AUX_W-1:0] start;
        logic [END_W-1:0] end_eff;
        logic             clear;
        logic [AUX_W-1:0] clear_start;
    } ring_cfg_t;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_ctl_t;

    typedef struct packed {
        logic [HOST_W-1:0] dma_host_address;
        logic [AUX_W-1:0]  dma_aux_address;
        logic [CNT_W-1:0]  segment_bytes;
        logic              to_aux;
        logic              issue_dma;
        logic              last;
        logic              overrun;
        logic [END_W-1:0]  bytes_used;
        logic [END_W-1:0]  bytes_free;
    } res_t;

endpackage

`default_nettype wire

/* rtl/core/rbds_channels.sv */
// ----------------------------------------------------------------------------
// rbds channels
// Valid/ready channels of the segmenter: request, result and register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbds_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 mode;
    logic [rbds_pkg::HOST_W-1:0] host_address;
    logic [rbds_pkg::CNT_W-1:0]  byte_count;

    modport source (output valid, mode, host_address, byte_count, input ready);
    modport sink   (input valid, mode, host_address, byte_count, output ready);
endinterface

interface rbds_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [rbds_pkg::HOST_W-1:0] dma_host_address;
    logic [rbds_pkg::AUX_W-1:0]  dma_aux_address;
    logic [rbds_pkg::CNT_W-1:0]  segment_bytes;
    logic                        to_aux;
    logic                        issue_dma;
    logic                        last;
    logic                        overrun;
    logic [rbds_pkg::END_W-1:0]  bytes_used;
    logic [rbds_pkg::END_W-1:0]  bytes_free;

    modport source (output valid, dma_host_address, dma_aux_address, segment_bytes,
                    to_aux, issue_dma, last, overrun, bytes_used, bytes_free,
                    input ready);
    modport sink   (input valid, dma_host_address, dma_aux_address, segment_bytes,
                    to_aux, issue_dma, last, overrun, bytes_used, bytes_free,
                    output ready);
endinterface

interface rbds_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [rbds_pkg::IDX_W-1:0] index;
    logic [rbds_pkg::END_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/rbds_alu.sv */
// ----------------------------------------------------------------------------
// rbds_alu
// The one shared adder/subtractor of the segmenter, with a borrow flag that
// serves every compare of the sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module rbds_alu (
    input  rbds_pkg::alu_ctl_t         ctl,
    output logic [rbds_pkg::ALU_W-1:0] res,
    output logic                       neg
);
    import rbds_pkg::*;

    logic [ALU_W:0] wide;

    always_comb
    begin
        if (ctl.sub)
        begin
            wide = {1'b0, ctl.a} - {1'b0, ctl.b};
        end
        else
        begin
            wide = {1'b0, ctl.a} + {1'b0, ctl.b};
        end
    end

    assign res = wide[ALU_W-1:0];
    // Operands stay below 2^ALU_W, so the top bit is the borrow of a subtract.
    assign neg = ctl.sub & wide[ALU_W];

endmodule

`default_nettype wire

/* rtl/core/rbds_seq.sv */
// ----------------------------------------------------------------------------
// rbds_seq
// Sequencer of the segmenter: steps one request through the shared adder,
// keeps the pointers and fill count, and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbds_seq (
    input  wire                 clk,
    input  wire                 rst_n,
    input  rbds_pkg::ring_cfg_t ring,
    rbds_req_if.sink            req,
    rbds_rsp_if.source          rsp
);
    import rbds_pkg::*;

    state_t             state_reg, state_next;
    logic [1:0]         mode_reg;
    logic [HOST_W-1:0]  host_reg, host2_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [PTR_W-1:0]   end_reg, cap_reg, avail_reg, first_reg, rest_reg;
    logic [PTR_W-1:0]   aux0_reg, ptr_new_reg, free_reg;
    logic [PTR_W-1:0]   fill_reg, rd_ptr_reg, wr_ptr_reg;
    logic               dma_reg, overrun_reg;
    res_t               out_reg;
    logic               out_valid_reg;

    alu_ctl_t           alu;
    logic [ALU_W-1:0]   alu_res;
    logic               alu_neg;
    logic [PTR_W-1:0]   alu_low;
    logic               writing;
    logic               slot_free;
    logic               load_out;
    logic [PTR_W-1:0]   cur_ptr;
    logic [PTR_W-1:0]   start_ext;
    logic [PTR_W-1:0]   count_ext;
    res_t               res_next;

    rbds_alu u_alu (
        .ctl (alu),
        .res (alu_res),
        .neg (alu_neg)
    );

    assign alu_low   = alu_res[PTR_W-1:0];
    assign writing   = (mode_reg == MODE_WRITE);
    assign cur_ptr   = writing ? wr_ptr_reg : rd_ptr_reg;
    assign start_ext = PTR_W'(ring.start);
    assign count_ext = PTR_W'(count_reg);
    assign slot_free = !out_valid_reg || rsp.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = ST_CAP;
                end
            end
            ST_CAP:
            begin
                if (mode_reg == MODE_CLEAR || mode_reg == MODE_NONE || count_reg == '0)
                begin
                    state_next = ST_FREE;
                end
                else
                begin
                    state_next = ST_AVAIL;
                end
            end
            ST_AVAIL: state_next = ST_CHECK;
            ST_CHECK: state_next = alu_neg ? ST_FREE : ST_FIRST;
            ST_FIRST: state_next = ST_MIN;
            ST_MIN:   state_next = ST_REST;
            ST_REST:  state_next = ST_ADV;
            ST_ADV:   state_next = ST_WRAP;
            ST_WRAP:  state_next = (rest_reg != '0) ? ST_ADV2 : ST_FILL;
            ST_ADV2:  state_next = ST_WRAP2;
            ST_WRAP2: state_next = ST_FILL;
            ST_FILL:  state_next = ST_FREE;
            ST_FREE:  state_next = ST_EMIT1;
            ST_EMIT1:
            begin
                if (slot_free)
                begin
                    state_next = (dma_reg && rest_reg != '0) ? ST_EMIT2 : ST_IDLE;
                end
            end
            ST_EMIT2:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Operand selection for the shared adder and handshake outputs.
    always_comb
    begin
        alu.a     = '0;
        alu.b     = '0;
        alu.sub   = 1'b1;
        req.ready = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  req.ready = 1'b1;
            ST_CAP:
            begin
                alu.a = ALU_W'(ring.end_eff);
                alu.b = ALU_W'(ring.start);
            end
            ST_AVAIL:
            begin
                alu.a = ALU_W'(cap_reg);
                alu.b = ALU_W'(fill_reg);
            end
            ST_CHECK:
            begin
                alu.a = writing ? ALU_W'(avail_reg) : ALU_W'(fill_reg);
                alu.b = ALU_W'(count_reg);
            end
            ST_FIRST:
            begin
                alu.a = ALU_W'(end_reg);
                alu.b = ALU_W'(cur_ptr);
            end
            ST_MIN:
            begin
                alu.a = ALU_W'(first_reg);
                alu.b = ALU_W'(count_reg);
            end
            ST_REST:
            begin
                alu.a = ALU_W'(count_reg);
                alu.b = ALU_W'(first_reg);
            end
            ST_ADV:
            begin
                alu.a   = ALU_W'(aux0_reg);
                alu.b   = ALU_W'(first_reg);
                alu.sub = 1'b0;
            end
            ST_WRAP, ST_WRAP2:
            begin
                alu.a = ALU_W'(ptr_new_reg);
                alu.b = ALU_W'(end_reg);
            end
            ST_ADV2:
            begin
                alu.a   = ALU_W'(ring.start);
                alu.b   = ALU_W'(rest_reg);
                alu.sub = 1'b0;
            end
            ST_FILL:
            begin
                alu.a   = ALU_W'(fill_reg);
                alu.b   = ALU_W'(count_reg);
                alu.sub = !writing;
            end
            ST_FREE:
            begin
                alu.a = ALU_W'(cap_reg);
                alu.b = ALU_W'(fill_reg);
            end
            ST_EMIT1:
            begin
                // Host address of a second segment, ready before it is needed.
                alu.a    = ALU_W'(host_reg);
                alu.b    = ALU_W'(first_reg);
                alu.sub  = 1'b0;
                load_out = slot_free;
            end
            ST_EMIT2: load_out = slot_free;
            default:
            begin
                alu.a = '0;
            end
        endcase
    end

    always_comb
    begin
        res_next.to_aux     = writing;
        res_next.bytes_used = fill_reg;
        res_next.bytes_free = free_reg;
        if (state_reg == ST_EMIT2)
        begin
            res_next.dma_host_address = host2_reg;
            res_next.dma_aux_address  = ring.start;
            res_next.segment_bytes    = rest_reg[CNT_W-1:0];
            res_next.issue_dma        = 1'b1;
            res_next.last             = 1'b1;
            res_next.overrun          = 1'b0;
        end
        else if (dma_reg)
        begin
            res_next.dma_host_address = host_reg;
            res_next.dma_aux_address  = aux0_reg[AUX_W-1:0];
            res_next.segment_bytes    = first_reg[CNT_W-1:0];
            res_next.issue_dma        = 1'b1;
            res_next.last             = (rest_reg == '0);
            res_next.overrun          = 1'b0;
        end
        else
        begin
            res_next.dma_host_address = '0;
            res_next.dma_aux_address  = '0;
            res_next.segment_bytes    = '0;
            res_next.issue_dma        = 1'b0;
            res_next.last             = 1'b1;
            res_next.overrun          = overrun_reg;
        end
    end

    // Control state and ring state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            rd_ptr_reg    <= PTR_W'(RING_START_RST);
            wr_ptr_reg    <= PTR_W'(RING_START_RST);
            dma_reg       <= 1'b0;
            overrun_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == ST_IDLE && req.valid)
            begin
                dma_reg     <= 1'b0;
                overrun_reg <= 1'b0;
            end
            if (state_reg == ST_CHECK)
            begin
                overrun_reg <= alu_neg;
                dma_reg     <= !alu_neg;
            end

            if (ring.clear)
            begin
                fill_reg   <= '0;
                rd_ptr_reg <= PTR_W'(ring.clear_start);
                wr_ptr_reg <= PTR_W'(ring.clear_start);
            end
            else if (state_reg == ST_CAP && mode_reg == MODE_CLEAR)
            begin
                fill_reg   <= '0;
                rd_ptr_reg <= start_ext;
                wr_ptr_reg <= start_ext;
            end
            else if (state_reg == ST_FILL)
            begin
                fill_reg <= alu_low;
                if (writing)
                begin
                    wr_ptr_reg <= ptr_new_reg;
                end
                else
                begin
                    rd_ptr_reg <= ptr_new_reg;
                end
            end
        end
    end

    // Working registers of the sequence.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req.valid)
        begin
            mode_reg  <= req.mode;
            host_reg  <= req.host_address;
            count_reg <= req.byte_count;
        end
        unique case (state_reg)
            ST_CAP:
            begin
                cap_reg <= alu_neg ? '0 : alu_low;
                end_reg <= alu_neg ? start_ext : ring.end_eff;
            end
            ST_AVAIL: avail_reg <= alu_neg ? '0 : alu_low;
            ST_FIRST:
            begin
                first_reg <= alu_low;
                aux0_reg  <= cur_ptr;
            end
            ST_MIN:
            begin
                if (!alu_neg)
                begin
                    first_reg <= count_ext;
                end
            end
            ST_REST:  rest_reg <= alu_low;
            ST_ADV, ST_ADV2: ptr_new_reg <= alu_low;
            ST_WRAP, ST_WRAP2:
            begin
                if (!alu_neg)
                begin
                    ptr_new_reg <= start_ext;
                end
            end
            ST_FREE:  free_reg <= alu_neg ? '0 : alu_low;
            ST_EMIT1: host2_reg <= alu_res[HOST_W-1:0];
            default:
            begin
            end
        endcase
        if (load_out)
        begin
            out_reg <= res_next;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.dma_host_address = out_reg.dma_host_address;
    assign rsp.dma_aux_address  = out_reg.dma_aux_address;
    assign rsp.segment_bytes    = out_reg.segment_bytes;
    assign rsp.to_aux           = out_reg.to_aux;
    assign rsp.issue_dma        = out_reg.issue_dma;
    assign rsp.last             = out_reg.last;
    assign rsp.overrun          = out_reg.overrun;
    assign rsp.bytes_used       = out_reg.bytes_used;
    assign rsp.bytes_free       = out_reg.bytes_free;

endmodule

`default_nettype wire

/* rtl/core/ring_buffer_dma_segmenter_unit.sv */
// ----------------------------------------------------------------------------
// ring_buffer_dma_segmenter_unit
// Byte ring in an auxiliary memory window, split into DMA segment commands.
// ----------------------------------------------------------------------------
// Usage: a request word on req (mode, host_address, byte_count) writes into,
// reads from or empties the ring. Each request gives one or two words on rsp:
// a DMA command per segment, split where the window wraps, or one status word
// for an empty request, a reset request or a refused request (overrun). Every
// word carries the fill count and free space after the request.
// The cfg channel writes ring_start (index 0) or ring_end (index 1); either
// write empties the ring. It is always ready and should only be used while
// the block is idle.
// Timing: each request steps through one shared adder, one operation a cycle,
// and its result words are registered; the second segment of a split request
// follows the first. req.ready is high only between requests, so a new
// request is taken only once the last one is through. A stalled receiver
// holds the result word and halts the sequence there.
// Reset empties the ring with ring_start 0x20 and ring_end 0x4000.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_buffer_dma_segmenter_unit #(
    parameter int AUX_ADDR_BITS = 24
) (
    input  wire         clk,
    input  wire         rst_n,
    rbds_req_if.sink    req,
    rbds_rsp_if.source  rsp,
    rbds_cfg_if.sink    cfg
);
    import rbds_pkg::*;

    localparam logic [ALU_W:0] AUX_LIMIT = (ALU_W + 1)'(1) << AUX_ADDR_BITS;

    logic [AUX_W-1:0] start_reg;
    logic [END_W-1:0] end_reg;
    logic             cfg_we;
    logic             hit_start;
    logic             hit_end;
    ring_cfg_t        ring;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid && cfg.ready;
    assign hit_start = (cfg.index == REG_RING_START);
    assign hit_end   = (cfg.index == REG_RING_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= RING_START_RST;
            end_reg   <= RING_END_RST;
        end
        else if (cfg_we)
        begin
            if (hit_start)
            begin
                start_reg <= cfg.data[AUX_W-1:0];
            end
            if (hit_end)
            begin
                end_reg <= cfg.data;
            end
        end
    end

    // The end address cannot lie beyond the auxiliary address space.
    always_comb
    begin
        ring.start       = start_reg;
        ring.end_eff     = ((ALU_W + 1)'(end_reg) > AUX_LIMIT) ? AUX_LIMIT[END_W-1:0]
                                                               : end_reg;
        ring.clear       = cfg_we && (hit_start || hit_end);
        ring.clear_start = hit_start ? cfg.data[AUX_W-1:0] : start_reg;
    end

    rbds_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .ring  (ring),
        .req   (req),
        .rsp   (rsp)
    );

    a_one_request_at_a_time : assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready
    ) else $error("request accepted while another is in progress");

    a_split_only_on_dma : assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> rsp.issue_dma
    ) else $error("non-final result word that is not a DMA command");

    a_overrun_is_status : assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.overrun) |-> (!rsp.issue_dma && rsp.last)
    ) else $error("refused request issued a DMA command");

    a_second_segment_at_start : assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && !rsp.last) |=>
            (rsp.valid && rsp.issue_dma && rsp.dma_aux_address == start_reg)
    ) else $error("wrapped segment does not begin at the ring start");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ring buffer DMA segmenter. A scoreboard keeps
// its own copy of the ring window, both pointers and the fill count, and
// works out the segment words that every accepted request should give. The
// words seen on rsp are checked field by field, in order. Requests are mostly
// writes and reads that fit the ring, so the pointers wrap often. The rest are
// refused, empty, unused and clearing requests, over several ring windows
// including the extremes. Both sides idle in random bursts.
// ----------------------------------------------------------------------------

class ring_segment_scoreboard;
    localparam longint unsigned AUX_SPAN = 64'd1 << rbds_pkg::AUX_W;

    bit [23:0]       ring_start;
    bit [24:0]       ring_end;
    longint unsigned rd_ptr;
    longint unsigned wr_ptr;
    longint unsigned fill;
    rbds_pkg::res_t  pending_segments[$];
    int              mismatches;

    function new();
        ring_start = rbds_pkg::RING_START_RST;
        ring_end   = rbds_pkg::RING_END_RST;
        mismatches = 0;
        empty_ring();
    endfunction

    function void empty_ring();
        rd_ptr = ring_start;
        wr_ptr = ring_start;
        fill   = 0;
    endfunction

    // The end is clamped to the address space and never falls below the start.
    function longint unsigned window_end();
        longint unsigned e;
        e = ring_end;
        if (e > AUX_SPAN)
            e = AUX_SPAN;
        if (e < ring_start)
            e = ring_start;
        return e;
    endfunction

    function longint unsigned capacity();
        return window_end() - ring_start;
    endfunction

    function void note_config(rbds_pkg::reg_idx_t idx, bit [24:0] value);
        if (idx == rbds_pkg::REG_RING_START)
            ring_start = value[23:0];
        else if (idx == rbds_pkg::REG_RING_END)
            ring_end = value;
        else
            return;
        empty_ring();
    endfunction

    function void push_result(bit [31:0] host, bit [23:0] aux, bit [23:0] len,
                              bit to_aux, bit dma, bit last_word, bit refused);
        rbds_pkg::res_t  r;
        longint unsigned cap;
        cap = capacity();
        r.dma_host_address = host;
        r.dma_aux_address  = aux;
        r.segment_bytes    = len;
        r.to_aux           = to_aux;
        r.issue_dma        = dma;
        r.last             = last_word;
        r.overrun          = refused;
        r.bytes_used       = 25'(fill);
        r.bytes_free       = 25'((cap >= fill) ? cap - fill : 0);
        pending_segments.push_back(r);
    endfunction

    function void note_request(rbds_pkg::mode_t mode, bit [31:0] host, bit [23:0] count);
        longint unsigned wend;
        longint unsigned cap;
        longint unsigned aux0;
        longint unsigned first;
        longint unsigned rest;
        longint unsigned nxt;
        bit              writing;
        wend    = window_end();
        cap     = wend - ring_start;
        writing = (mode == rbds_pkg::MODE_WRITE);
        if (mode == rbds_pkg::MODE_CLEAR) begin
            empty_ring();
            push_result(0, 0, 0, 1'b0, 1'b0, 1'b1, 1'b0);
            return;
        end
        if (mode == rbds_pkg::MODE_NONE || count == 0) begin
            push_result(0, 0, 0, writing, 1'b0, 1'b1, 1'b0);
            return;
        end
        if (writing ? (count > cap - fill) : (count > fill)) begin
            push_result(0, 0, 0, writing, 1'b0, 1'b1, 1'b1);
            return;
        end
        aux0  = writing ? wr_ptr : rd_ptr;
        first = wend - aux0;
        if (first > count)
            first = count;
        rest = count - first;
        nxt  = aux0 + first;
        if (nxt >= wend)
            nxt = ring_start;
        if (rest != 0) begin
            nxt = ring_start + rest;
            if (nxt >= wend)
                nxt = ring_start;
        end
        if (writing) begin
            wr_ptr = nxt;
            fill   = fill + count;
        end
        else begin
            rd_ptr = nxt;
            fill   = fill - count;
        end
        push_result(host, 24'(aux0), 24'(first), writing, 1'b1, rest == 0, 1'b0);
        if (rest != 0)
            push_result(32'(host + first), ring_start, 24'(rest), writing, 1'b1, 1'b1, 1'b0);
    endfunction

    function void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endfunction

    function void compare_field(string field, logic [32:0] want, logic [32:0] got);
        if (got !== want)
            log_mismatch($sformatf("%s expected %h, got %h", field, want, got));
    endfunction

    function void check_segment(rbds_pkg::res_t got);
        rbds_pkg::res_t want;
        if (pending_segments.size() == 0) begin
            log_mismatch($sformatf("result word %h with none expected", got));
            return;
        end
        want = pending_segments.pop_front();
        compare_field("dma_host_address", want.dma_host_address, got.dma_host_address);
        compare_field("dma_aux_address", want.dma_aux_address, got.dma_aux_address);
        compare_field("segment_bytes", want.segment_bytes, got.segment_bytes);
        compare_field("to_aux", want.to_aux, got.to_aux);
        compare_field("issue_dma", want.issue_dma, got.issue_dma);
        compare_field("last", want.last, got.last);
        compare_field("overrun", want.overrun, got.overrun);
        compare_field("bytes_used", want.bytes_used, got.bytes_used);
        compare_field("bytes_free", want.bytes_free, got.bytes_free);
    endfunction
endclass

module tb_top;
    import rbds_pkg::*;

    localparam int          STALL_LIMIT   = 2000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          END_CYCLES    = 20;
    localparam logic [23:0] MAX_COUNT     = 24'hFF_FFFF;
    localparam int          DEFAULT_CAP   = int'(RING_END_RST) - int'(RING_START_RST);

    logic clk;
    logic rst_n;
    bit   quiet;
    int   idle_cycles;

    ring_segment_scoreboard sb;

    rbds_req_if req_ch ();
    rbds_rsp_if rsp_ch ();
    rbds_cfg_if cfg_ch ();

    ring_buffer_dma_segmenter_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: ready drops in random bursts until the quiet tail of the run.
    initial
    begin
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && stall == 0 && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 17);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Checks every result word taken and ends the run if nothing moves for long.
    always @(posedge clk)
    begin : result_monitor
        res_t seen;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            seen.dma_host_address = rsp_ch.dma_host_address;
            seen.dma_aux_address  = rsp_ch.dma_aux_address;
            seen.segment_bytes    = rsp_ch.segment_bytes;
            seen.to_aux           = rsp_ch.to_aux;
            seen.issue_dma        = rsp_ch.issue_dma;
            seen.last             = rsp_ch.last;
            seen.overrun          = rsp_ch.overrun;
            seen.bytes_used       = rsp_ch.bytes_used;
            seen.bytes_free       = rsp_ch.bytes_free;
            sb.check_segment(seen);
        end
        if ((rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
            (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Leaves valid high after acceptance, so back-to-back words need no gap.
    task automatic send_request(mode_t m, logic [31:0] host, logic [23:0] count);
        req_ch.valid        <= 1'b1;
        req_ch.mode         <= m;
        req_ch.host_address <= host;
        req_ch.byte_count   <= count;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(m, host, count);
    endtask

    task automatic pause_sender(int unsigned cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (sb.pending_segments.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(reg_idx_t idx, logic [24:0] value);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.note_config(idx, value);
    endtask

    task automatic set_window(logic [24:0] start_value, logic [24:0] end_value);
        write_register(REG_RING_START, start_value);
        write_register(REG_RING_END, end_value);
    endtask

    // Mostly short transfers, now and then one up to the whole room available.
    function automatic logic [23:0] draw_count(longint unsigned room);
        longint unsigned lim;
        lim = (room > MAX_COUNT) ? MAX_COUNT : room;
        if ($urandom_range(0, 2) != 0 && lim > 64)
            lim = 64;
        return 24'($urandom_range(1, 32'(lim)));
    endfunction

    task automatic send_random_request();
        longint unsigned room;
        longint unsigned held;
        int unsigned     pick;
        mode_t           m;
        logic [23:0]     count;
        room  = sb.capacity() - sb.fill;
        held  = sb.fill;
        pick  = $urandom_range(0, 99);
        m     = mode_t'($urandom_range(0, 3));
        count = 24'($urandom);
        if (pick < 42 && room != 0) begin
            m     = MODE_WRITE;
            count = draw_count(room);
        end
        else if (pick < 82 && held != 0) begin
            m     = MODE_READ;
            count = draw_count(held);
        end
        else if (pick < 87) begin
            // Ask for more than the ring can give or take.
            if (room < MAX_COUNT) begin
                m     = MODE_WRITE;
                count = 24'($urandom_range(32'(room) + 1, MAX_COUNT));
            end
            else if (held < MAX_COUNT) begin
                m     = MODE_READ;
                count = 24'($urandom_range(32'(held) + 1, MAX_COUNT));
            end
        end
        else if (pick < 91) begin
            m     = mode_t'($urandom_range(0, 1));
            count = '0;
        end
        else if (pick < 94)
            m = MODE_CLEAR;
        send_request(m, $urandom, count);
    endtask

    task automatic run_random(int unsigned items);
        for (int unsigned i = 0; i < items; i++) begin
            if (!quiet && $urandom_range(0, 4) == 0)
                pause_sender($urandom_range(1, 17));
            send_random_request();
        end
    endtask

    // Runs in the reset window, so the ring capacity is known.
    task automatic directed_requests();
        send_request(MODE_WRITE, $urandom, 24'd0);
        send_request(MODE_READ, $urandom, 24'd0);
        send_request(MODE_NONE, 32'hFFFF_FFFF, MAX_COUNT);
        send_request(MODE_READ, 32'h0, 24'd1);
        send_request(MODE_WRITE, $urandom, MAX_COUNT);
        // Fill the ring exactly to its end, then try one byte more.
        send_request(MODE_WRITE, 32'hFFFF_FFFF, 24'(DEFAULT_CAP));
        send_request(MODE_WRITE, $urandom, 24'd1);
        send_request(MODE_READ, 32'h0, 24'd100);
        send_request(MODE_READ, $urandom, 24'(DEFAULT_CAP - 100));
        // Both pointers now split at the wrap point, the host address wraps too.
        send_request(MODE_WRITE, $urandom, 24'd16000);
        send_request(MODE_READ, $urandom, 24'd10000);
        send_request(MODE_WRITE, 32'hFFFF_FF00, 24'd10000);
        send_request(MODE_READ, $urandom, 24'd16000);
        send_request(MODE_WRITE, $urandom, 24'd5);
        send_request(MODE_CLEAR, 32'h0, 24'd0);
        send_request(MODE_READ, $urandom, 24'd1);
        send_request(MODE_CLEAR, $urandom, 24'($urandom));
    endtask

    initial
    begin
        logic [24:0] base;
        sb          = new();
        quiet       = 1'b0;
        idle_cycles = 0;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.mode         <= '0;
        req_ch.host_address <= '0;
        req_ch.byte_count   <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_RING_START;
        cfg_ch.data         <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        directed_requests();
        run_random(45);
        drain_results();
        run_random(45);

        set_window(25'd100, 25'd164);
        run_random(110);
        set_window(25'd0, 25'h100_0000);
        run_random(70);
        // Bit 24 of the start is dropped, and the end saturates at the top.
        set_window(25'h1FF_FFF0, 25'h1FF_FFFF);
        run_random(70);
        set_window(25'd5000, 25'd100);
        run_random(30);
        set_window(25'h0FF_FFFF, 25'h1FF_FFFF);
        run_random(40);
        repeat (3)
        begin
            base = 25'($urandom_range(0, 24'hFF_F000));
            set_window(base, base + 25'($urandom_range(1, 4096)));
            run_random(60);
        end

        quiet = 1'b1;
        set_window(25'd32, 25'd2000);
        run_random(80);

        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_segments.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
